### rtl/knrn_pkg.sv
// ----------------------------------------------------------------------------
// knrn_pkg
// Shared types, character codes and constants of the kanji numeral run
// normalizer.
// ----------------------------------------------------------------------------
package knrn_pkg;

  localparam int PAD_DIGITS  = 20;
  localparam int VALUE_BITS  = 64;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CONV_BITS   = 4;
  localparam int CONV_STEPS  = VALUE_BITS / CONV_BITS;
  localparam int CONV_CNT_W  = $clog2(CONV_STEPS);
  localparam int DIG_CNT_W   = $clog2(PAD_DIGITS);
  localparam int BCD_W       = PAD_DIGITS * 4;

  localparam logic [15:0] MARK_OPEN  = 16'h0001;
  localparam logic [15:0] MARK_CLOSE = 16'h0002;
  localparam logic [15:0] ASCII_ZERO = 16'h0030;

  // Numeral characters.
  localparam logic [15:0] CH_ZERO_A = 16'h3007;
  localparam logic [15:0] CH_ZERO_B = 16'h96F6;
  localparam logic [15:0] CH_ONE    = 16'h4E00;
  localparam logic [15:0] CH_TWO    = 16'h4E8C;
  localparam logic [15:0] CH_THREE  = 16'h4E09;
  localparam logic [15:0] CH_FOUR   = 16'h56DB;
  localparam logic [15:0] CH_FIVE   = 16'h4E94;
  localparam logic [15:0] CH_SIX    = 16'h516D;
  localparam logic [15:0] CH_SEVEN  = 16'h4E03;
  localparam logic [15:0] CH_EIGHT  = 16'h516B;
  localparam logic [15:0] CH_NINE   = 16'h4E5D;
  localparam logic [15:0] CH_TEN    = 16'h5341;
  localparam logic [15:0] CH_HUNDRED = 16'h767E;
  localparam logic [15:0] CH_THOUSAND = 16'h5343;
  localparam logic [15:0] CH_MAN    = 16'h4E07;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_unit;
    logic        out_last;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_DIGIT,
    OP_SMALL,
    OP_MAN,
    OP_OTHER
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [3:0]  digit;
    logic [9:0]  unit;
    logic [15:0] code;
    logic        last;
  } op_t;

  typedef enum logic [2:0] {
    BK_ACCUM,
    BK_FOLD,
    BK_SUM,
    BK_CONV,
    BK_OPEN,
    BK_DIGITS,
    BK_CLOSE,
    BK_HELD
  } back_state_t;

  // Sorts one code unit into digit, small unit, the 10000 unit or anything else.
  function automatic op_t classify(input in_item_t it);
    op_t op;
    op.kind  = OP_OTHER;
    op.digit = 4'd0;
    op.unit  = 10'd0;
    op.code  = it.code_unit;
    op.last  = it.is_last;
    case (it.code_unit)
      CH_ZERO_A, CH_ZERO_B: begin op.kind = OP_DIGIT; op.digit = 4'd0; end
      CH_ONE:      begin op.kind = OP_DIGIT; op.digit = 4'd1; end
      CH_TWO:      begin op.kind = OP_DIGIT; op.digit = 4'd2; end
      CH_THREE:    begin op.kind = OP_DIGIT; op.digit = 4'd3; end
      CH_FOUR:     begin op.kind = OP_DIGIT; op.digit = 4'd4; end
      CH_FIVE:     begin op.kind = OP_DIGIT; op.digit = 4'd5; end
      CH_SIX:      begin op.kind = OP_DIGIT; op.digit = 4'd6; end
      CH_SEVEN:    begin op.kind = OP_DIGIT; op.digit = 4'd7; end
      CH_EIGHT:    begin op.kind = OP_DIGIT; op.digit = 4'd8; end
      CH_NINE:     begin op.kind = OP_DIGIT; op.digit = 4'd9; end
      CH_TEN:      begin op.kind = OP_SMALL; op.unit = 10'd10; end
      CH_HUNDRED:  begin op.kind = OP_SMALL; op.unit = 10'd100; end
      CH_THOUSAND: begin op.kind = OP_SMALL; op.unit = 10'd1000; end
      CH_MAN:      begin op.kind = OP_MAN; end
      default:     begin op.kind = OP_OTHER; end
    endcase
    return op;
  endfunction

endpackage

### rtl/knrn_front.sv
// ----------------------------------------------------------------------------
// knrn_front
// Input stage: takes code units, classifies them and hands them to the queue.
// ----------------------------------------------------------------------------
module knrn_front import knrn_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t item,
  input  logic     q_full,
  output logic     q_wr,
  output op_t      q_op
);

  logic valid;
  op_t  op;
  logic accept;

  assign full   = valid & q_full;
  assign accept = push & ~full;
  assign q_wr   = valid;
  assign q_op   = op;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= accept | (valid & q_full);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= classify(item);
    end
  end

endmodule

### rtl/knrn_queue.sv
// ----------------------------------------------------------------------------
// knrn_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module knrn_queue import knrn_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  op_t  wr_op,
  output logic full,
  input  logic rd,
  output op_t  rd_op,
  output logic empty
);

  op_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;
  logic              do_wr;
  logic              do_rd;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr & ~full;
  assign do_rd = rd & ~empty;
  assign rd_op = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (QPTR_W+1)'(do_wr) - (QPTR_W+1)'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_op;
    end
  end

endmodule

### rtl/knrn_back.sv
// ----------------------------------------------------------------------------
// knrn_back
// Run accumulator, binary to decimal conversion and result sequencing,
// with a two-entry result queue at its output.
// ----------------------------------------------------------------------------
module knrn_back import knrn_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  op_t       op,
  input  logic      op_valid,
  output logic      op_pop,
  output out_item_t result,
  output logic      empty,
  input  logic      pop
);

  back_state_t state;
  back_state_t state_next;

  logic                  in_run;
  logic [3:0]            current_digit;
  logic [VALUE_BITS-1:0] section_sum;
  logic [VALUE_BITS-1:0] total_sum;
  logic                  man_pend;
  logic [VALUE_BITS-1:0] man_op;
  logic [VALUE_BITS-1:0] bin;
  logic [BCD_W-1:0]      decimal_digits;
  logic [CONV_CNT_W-1:0] step_cnt;
  logic [DIG_CNT_W-1:0]  dig_cnt;
  logic                  close_last;
  logic                  has_held;
  out_item_t             held_unit;

  out_item_t  ofifo [2];
  logic       owr;
  logic       ord;
  logic [1:0] ocount;
  logic       out_space;
  logic       out_wr;
  out_item_t  out_data;
  logic       out_rd;

  logic [VALUE_BITS-1:0] man_prod;
  logic [13:0]           small_prod;
  logic [3:0]            digit_mult;
  logic [VALUE_BITS-1:0] sec_plus;

  // Four double-dabble steps: correct each BCD digit, then shift one bit in.
  function automatic logic [BCD_W+VALUE_BITS-1:0] dabble(
    input logic [BCD_W+VALUE_BITS-1:0] v);
    logic [BCD_W+VALUE_BITS-1:0] w;
    w = v;
    for (int s = 0; s < CONV_BITS; s++) begin
      for (int d = 0; d < PAD_DIGITS; d++) begin
        if (w[VALUE_BITS + 4*d +: 4] >= 4'd5) begin
          w[VALUE_BITS + 4*d +: 4] = w[VALUE_BITS + 4*d +: 4] + 4'd3;
        end
      end
      w = w << 1;
    end
    return w;
  endfunction

  // Times 10000 as a sum of shifted copies.
  assign man_prod = (man_op << 13) + (man_op << 10) + (man_op << 9)
                  + (man_op << 8) + (man_op << 4);
  assign digit_mult = (current_digit == 4'd0) ? 4'd1 : current_digit;
  assign small_prod = 14'(digit_mult) * 14'(op.unit);
  assign sec_plus   = section_sum + VALUE_BITS'(current_digit);

  assign out_space = (ocount != 2'd2);
  assign empty     = (ocount == 2'd0);
  assign out_rd    = pop & ~empty;
  assign result    = ofifo[ord];

  always_comb begin
    state_next = state;
    case (state)
      BK_ACCUM: begin
        if (op_pop) begin
          if (op.kind == OP_OTHER) begin
            if (in_run) begin
              state_next = BK_FOLD;
            end
          end else if (op.last) begin
            state_next = BK_FOLD;
          end
        end
      end
      BK_FOLD: state_next = BK_SUM;
      BK_SUM:  state_next = BK_CONV;
      BK_CONV: begin
        if (step_cnt == CONV_CNT_W'(CONV_STEPS-1)) begin
          state_next = BK_OPEN;
        end
      end
      BK_OPEN: begin
        if (out_space) begin
          state_next = BK_DIGITS;
        end
      end
      BK_DIGITS: begin
        if (out_space && dig_cnt == DIG_CNT_W'(PAD_DIGITS-1)) begin
          state_next = BK_CLOSE;
        end
      end
      BK_CLOSE: begin
        if (out_space) begin
          state_next = has_held ? BK_HELD : BK_ACCUM;
        end
      end
      BK_HELD: begin
        if (out_space) begin
          state_next = BK_ACCUM;
        end
      end
      default: state_next = BK_ACCUM;
    endcase
  end

  always_comb begin
    op_pop   = 1'b0;
    out_wr   = 1'b0;
    out_data = held_unit;
    case (state)
      BK_ACCUM: begin
        op_pop = op_valid & out_space;
        if (op_pop && op.kind == OP_OTHER && !in_run) begin
          out_wr            = 1'b1;
          out_data.out_unit = op.code;
          out_data.out_last = op.last;
        end
      end
      BK_OPEN: begin
        out_wr            = out_space;
        out_data.out_unit = MARK_OPEN;
        out_data.out_last = 1'b0;
      end
      BK_DIGITS: begin
        out_wr            = out_space;
        out_data.out_unit = ASCII_ZERO + 16'(decimal_digits[BCD_W-1 -: 4]);
        out_data.out_last = 1'b0;
      end
      BK_CLOSE: begin
        out_wr            = out_space;
        out_data.out_unit = MARK_CLOSE;
        out_data.out_last = close_last;
      end
      BK_HELD: begin
        out_wr   = out_space;
        out_data = held_unit;
      end
      default: begin
        out_wr = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_ACCUM;
      in_run        <= 1'b0;
      current_digit <= 4'd0;
      section_sum   <= '0;
      total_sum     <= '0;
      man_pend      <= 1'b0;
      held_unit     <= '0;
    end else begin
      state    <= state_next;
      man_pend <= 1'b0;
      if (man_pend) begin
        total_sum <= total_sum + man_prod;
      end
      if (state == BK_ACCUM && op_pop) begin
        case (op.kind)
          OP_DIGIT: begin
            current_digit <= op.digit;
            in_run        <= 1'b1;
          end
          OP_SMALL: begin
            section_sum   <= section_sum + VALUE_BITS'(small_prod);
            current_digit <= 4'd0;
            in_run        <= 1'b1;
          end
          OP_MAN: begin
            man_pend      <= 1'b1;
            section_sum   <= '0;
            current_digit <= 4'd0;
            in_run        <= 1'b1;
          end
          OP_OTHER: begin
            held_unit.out_unit <= op.code;
            held_unit.out_last <= op.last;
          end
          default: begin
            in_run <= in_run;
          end
        endcase
      end
      if (state == BK_SUM) begin
        total_sum     <= '0;
        section_sum   <= '0;
        current_digit <= 4'd0;
        in_run        <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_ACCUM && op_pop) begin
      close_last <= (op.kind != OP_OTHER);
      has_held   <= (op.kind == OP_OTHER);
      if (op.kind == OP_MAN) begin
        man_op <= (sec_plus == '0) ? VALUE_BITS'(1) : sec_plus;
      end
    end
    case (state)
      BK_SUM: begin
        bin            <= total_sum + section_sum + VALUE_BITS'(current_digit);
        decimal_digits <= '0;
        step_cnt       <= '0;
      end
      BK_CONV: begin
        {decimal_digits, bin} <= dabble({decimal_digits, bin});
        step_cnt              <= step_cnt + 1'b1;
      end
      BK_OPEN: begin
        dig_cnt <= '0;
      end
      BK_DIGITS: begin
        if (out_space) begin
          decimal_digits <= decimal_digits << 4;
          dig_cnt        <= dig_cnt + 1'b1;
        end
      end
      default: begin
        step_cnt <= step_cnt;
      end
    endcase
  end

  // Result queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      owr    <= 1'b0;
      ord    <= 1'b0;
      ocount <= 2'd0;
    end else begin
      if (out_wr) begin
        owr <= ~owr;
      end
      if (out_rd) begin
        ord <= ~ord;
      end
      ocount <= ocount + 2'(out_wr) - 2'(out_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (out_wr) begin
      ofifo[owr] <= out_data;
    end
  end

endmodule

### rtl/kanji_numeral_run_normalizer.sv
// ----------------------------------------------------------------------------
// kanji_numeral_run_normalizer
// Rewrites a UTF-16 string into a sort key: runs of Japanese numerals become
// 0x0001, a zero-padded decimal value and 0x0002; other code units pass.
// ----------------------------------------------------------------------------
//
//   Channel  | Handshake      | Accepted when     | Payload
//   ---------+----------------+-------------------+---------------------------
//   input    | push / full    | push && !full     | item   (code_unit, is_last)
//   result   | pop / empty    | pop && !empty     | result (out_unit, out_last)
//
// Code units are taken one per cycle while full is low; a unit that passes
// through goes through the input register, the queue and the result queue.
// When a run closes, the back end folds in the last 10000 group, sums the
// run value and converts it to decimal four bits per cycle, then sends
// PAD_DIGITS + 2 items one per cycle while the result queue has space, plus
// the code unit that closed the run if it was not a numeral.
// The input stage and the four-entry queue keep taking items during that time
// until they fill. Reset is synchronous and empties every queue.
//
module kanji_numeral_run_normalizer import knrn_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  // Classified items travel from the front to the back through the queue.
  logic q_wr;
  op_t  q_wr_op;
  logic q_full;
  logic q_rd;
  op_t  q_rd_op;
  logic q_empty;

  knrn_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_full (q_full),
    .q_wr   (q_wr),
    .q_op   (q_wr_op)
  );

  knrn_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wr_op (q_wr_op),
    .full  (q_full),
    .rd    (q_rd),
    .rd_op (q_rd_op),
    .empty (q_empty)
  );

  // The back end owns the run state and the result queue.
  knrn_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op       (q_rd_op),
    .op_valid (~q_empty),
    .op_pop   (q_rd),
    .result   (result),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

### rtl/knrn_checker.sv
// ----------------------------------------------------------------------------
// knrn_port_checks
// Port-level checks of the normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module knrn_port_checks import knrn_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      push,
  input logic      full,
  input in_item_t  item,
  input logic      empty,
  input logic      pop,
  input out_item_t result
);

  // A waiting result that is not taken stays on the ports.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("result changed while stalled");

  // Reset leaves the result queue empty and the input side not full.
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> (empty && !full))
    else $error("queues not empty after reset");

  // Without new items the input side cannot become full.
  a_no_spurious_full: assert property (@(posedge clk) disable iff (rst)
    (!full && !push) |=> !full)
    else $error("full rose without an accepted item");

endmodule

bind kanji_numeral_run_normalizer knrn_port_checks u_knrn_port_checks (.*);
